// File: design/rse_pkg.sv
// ---------------------------------------------------------------------------
// rse_pkg
// Shared constants, types and GF(256) arithmetic for the Reed-Solomon encoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rse_pkg;

  localparam int MaxParityPairs = 16;
  localparam int MaxPar         = 2 * MaxParityPairs;
  localparam int MaxCodeLen     = 255;
  localparam int SymW           = 8;
  localparam int IdxW           = $clog2(MaxPar);
  localparam int NbW            = $clog2(MaxPar + 1);

  // register indexes on the configuration port
  localparam logic [1:0] RegFieldPoly   = 2'd0;
  localparam logic [1:0] RegParityPairs = 2'd1;
  localparam logic [1:0] RegDataLen     = 2'd2;

  typedef logic [MaxPar-1:0][SymW-1:0] rse_vec_t;

  // effective configuration as seen by the datapath
  typedef struct packed {
    logic [SymW-1:0] red;
    logic [NbW-1:0]  nb;
    logic [SymW-1:0] k;
    logic            bad;
  } rse_cfg_t;

  function automatic logic [SymW-1:0] gf_mul(input logic [SymW-1:0] a,
                                             input logic [SymW-1:0] b,
                                             input logic [SymW-1:0] red);
    logic [SymW-1:0] x;
    logic [SymW-1:0] acc;
    logic            carry;
    x   = a;
    acc = '0;
    for (int i = 0; i < SymW; i++) begin
      if (b[i]) acc = acc ^ x;
      carry = x[SymW-1];
      x     = {x[SymW-2:0], 1'b0};
      if (carry) x = x ^ red;
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// File: design/reed_solomon_systematic_encoder.sv
// ---------------------------------------------------------------------------
// reed_solomon_systematic_encoder
// Systematic RS encoder over GF(256) with APB configuration.
// ---------------------------------------------------------------------------
// One data word is taken per clock unless input stalls; the last word of a
// message goes via the input register into the parity buffer, and the 2t
// parity words then leave at one per cycle while parity_ready_i is high, as
// the next message already streams in. Input stalls during a generator rebuild
// and when a last word arrives before the previous parity drain ends (single
// parity buffer). After reset and each write to a used register the generator
// is rebuilt, one root factor per cycle; the write drops a partial message.
`timescale 1ns / 1ps
`default_nettype none

module reed_solomon_systematic_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // data words in
  input  wire logic        data_valid_i,
  output logic             data_ready_o,
  input  wire logic [7:0]  data_symbol_i,
  // parity words out
  output logic             parity_valid_o,
  input  wire logic        parity_ready_i,
  output logic [7:0]       parity_symbol_o,
  output logic [4:0]       parity_index_o,
  output logic             last_parity_o,
  output logic             bad_setup_o
);

  logic [8:0]        field_poly_q;
  logic [4:0]        parity_pairs_q;
  logic [7:0]        data_len_q;
  logic [1:0]        reg_idx;
  logic              cfg_wr;
  logic              cfg_start;
  logic [4:0]        t_eff;
  rse_pkg::rse_cfg_t cfg;
  logic              gen_busy;
  rse_pkg::rse_vec_t gen;
  logic              load;
  rse_pkg::rse_vec_t rem;
  logic              buf_free;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_poly_q   <= 9'd285;
      parity_pairs_q <= 5'd8;
      data_len_q     <= 8'd239;
    end else if (cfg_wr) begin
      case (reg_idx)
        rse_pkg::RegFieldPoly:   field_poly_q   <= pwdata[8:0];
        rse_pkg::RegParityPairs: parity_pairs_q <= pwdata[4:0];
        rse_pkg::RegDataLen:     data_len_q     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rse_pkg::RegFieldPoly:   prdata = {23'd0, field_poly_q};
      rse_pkg::RegParityPairs: prdata = {27'd0, parity_pairs_q};
      rse_pkg::RegDataLen:     prdata = {24'd0, data_len_q};
      default:                 prdata = '0;
    endcase
  end

  // a write to an unused address rebuilds nothing
  assign cfg_start = cfg_wr && (reg_idx inside {rse_pkg::RegFieldPoly,
                                                rse_pkg::RegParityPairs,
                                                rse_pkg::RegDataLen});

  always_comb begin
    if (parity_pairs_q == '0)
      t_eff = 5'd1;
    else if (parity_pairs_q > 5'(rse_pkg::MaxParityPairs))
      t_eff = 5'(rse_pkg::MaxParityPairs);
    else
      t_eff = parity_pairs_q;
  end

  assign cfg.red = field_poly_q[7:0];
  assign cfg.nb  = rse_pkg::NbW'({t_eff, 1'b0});
  assign cfg.k   = (data_len_q == '0) ? 8'd1 : data_len_q;
  assign cfg.bad = ({1'b0, cfg.k} + 9'(cfg.nb)) > 9'(rse_pkg::MaxCodeLen);

  rse_gen_builder u_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_start),
    .cfg_i   (cfg),
    .busy_o  (gen_busy),
    .gen_o   (gen)
  );

  rse_lfsr u_lfsr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (cfg_start),
    .hold_i     (gen_busy),
    .cfg_i      (cfg),
    .gen_i      (gen),
    .valid_i    (data_valid_i),
    .ready_o    (data_ready_o),
    .symbol_i   (data_symbol_i),
    .buf_free_i (buf_free),
    .load_o     (load),
    .rem_o      (rem)
  );

  rse_parity_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .load_i   (load),
    .rem_i    (rem),
    .free_o   (buf_free),
    .valid_o  (parity_valid_o),
    .ready_i  (parity_ready_i),
    .symbol_o (parity_symbol_o),
    .index_o  (parity_index_o),
    .last_o   (last_parity_o),
    .bad_o    (bad_setup_o)
  );

  // no word is taken while the generator is rebuilt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_busy |-> !data_ready_o)
    else $error("data accepted during generator build");

  // a write to a configuration register always restarts the generator build
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_start |=> gen_busy)
    else $error("generator build not started after write");

  // a new remainder never overwrites parity still to be sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!parity_valid_o || (parity_ready_i && last_parity_o)))
    else $error("parity buffer overrun");

endmodule

`default_nettype wire

// File: design/rse_gen_builder.sv
// ---------------------------------------------------------------------------
// rse_gen_builder
// Builds the generator polynomial prod (x + a^i), one root factor per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rse_gen_builder (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire rse_pkg::rse_cfg_t cfg_i,
  output logic                   busy_o,
  output rse_pkg::rse_vec_t      gen_o
);

  typedef logic [rse_pkg::MaxPar:0][rse_pkg::SymW-1:0] poly_t;

  poly_t                          poly_q, poly_d;
  logic [rse_pkg::SymW-1:0]       root_q;
  logic [rse_pkg::IdxW-1:0]       deg_q;
  logic                           busy_q;
  logic [rse_pkg::IdxW-1:0]       last_deg;

  assign last_deg = rse_pkg::IdxW'(cfg_i.nb - rse_pkg::NbW'(1));

  // multiply the running product by (x + root)
  always_comb begin
    poly_d[0] = rse_pkg::gf_mul(poly_q[0], root_q, cfg_i.red);
    for (int i = 1; i <= rse_pkg::MaxPar; i++) begin
      poly_d[i] = poly_q[i-1] ^ rse_pkg::gf_mul(poly_q[i], root_q, cfg_i.red);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      poly_q <= poly_t'(1);
      root_q <= rse_pkg::SymW'(1);
      deg_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      poly_q <= poly_t'(1);
      root_q <= rse_pkg::SymW'(1);
      deg_q  <= '0;
    end else if (busy_q) begin
      poly_q <= poly_d;
      root_q <= rse_pkg::gf_mul(root_q, rse_pkg::SymW'(2), cfg_i.red);
      deg_q  <= deg_q + rse_pkg::IdxW'(1);
      if (deg_q == last_deg) busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign gen_o  = poly_q[rse_pkg::MaxPar-1:0];

endmodule

`default_nettype wire

// File: design/rse_lfsr.sv
// ---------------------------------------------------------------------------
// rse_lfsr
// Input register and LFSR division register; hands the remainder over on the
// last data word of a message.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rse_lfsr (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     clear_i,
  input  wire logic                     hold_i,
  input  wire rse_pkg::rse_cfg_t        cfg_i,
  input  wire rse_pkg::rse_vec_t        gen_i,
  input  wire logic                     valid_i,
  output logic                          ready_o,
  input  wire logic [rse_pkg::SymW-1:0] symbol_i,
  input  wire logic                     buf_free_i,
  output logic                          load_o,
  output rse_pkg::rse_vec_t             rem_o
);

  logic                     in_valid_q;
  logic [rse_pkg::SymW-1:0] data_q;
  rse_pkg::rse_vec_t        rem_q, rem_d;
  logic [rse_pkg::SymW-1:0] cnt_q;
  logic [rse_pkg::IdxW-1:0] top_idx;
  logic [rse_pkg::SymW-1:0] fb;
  logic                     final_word;
  logic                     advance;

  assign top_idx    = rse_pkg::IdxW'(cfg_i.nb - rse_pkg::NbW'(1));
  assign fb         = rem_q[top_idx] ^ data_q;
  assign final_word = (cnt_q == cfg_i.k - rse_pkg::SymW'(1));
  // the last word waits until the parity buffer can take the remainder
  assign advance    = in_valid_q && !hold_i && (!final_word || buf_free_i);
  assign ready_o    = !hold_i && (!in_valid_q || advance);

  always_comb begin
    rem_d[0] = rse_pkg::gf_mul(fb, gen_i[0], cfg_i.red);
    for (int j = 1; j < rse_pkg::MaxPar; j++) begin
      rem_d[j] = rse_pkg::gf_mul(fb, gen_i[j], cfg_i.red) ^ rem_q[j-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      rem_q      <= '0;
      cnt_q      <= '0;
    end else if (clear_i) begin
      in_valid_q <= 1'b0;
      rem_q      <= '0;
      cnt_q      <= '0;
    end else begin
      if (ready_o) in_valid_q <= valid_i;
      if (advance) begin
        if (final_word) begin
          rem_q <= '0;
          cnt_q <= '0;
        end else begin
          rem_q <= rem_d;
          cnt_q <= cnt_q + rse_pkg::SymW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= symbol_i;
  end

  assign load_o = advance && final_word;
  assign rem_o  = rem_d;

endmodule

`default_nettype wire

// File: design/rse_parity_out.sv
// ---------------------------------------------------------------------------
// rse_parity_out
// Parity buffer; sends the remainder out highest power first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rse_parity_out (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire rse_pkg::rse_cfg_t         cfg_i,
  input  wire logic                      load_i,
  input  wire rse_pkg::rse_vec_t         rem_i,
  output logic                           free_o,
  output logic                           valid_o,
  input  wire logic                      ready_i,
  output logic [rse_pkg::SymW-1:0]       symbol_o,
  output logic [rse_pkg::IdxW-1:0]       index_o,
  output logic                           last_o,
  output logic                           bad_o
);

  rse_pkg::rse_vec_t        buf_q;
  logic [rse_pkg::IdxW-1:0] idx_q;
  logic                     busy_q;
  logic                     bad_q;
  logic                     at_last;

  assign at_last = (idx_q == '0);
  assign free_o  = !busy_q || (ready_i && at_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= rse_pkg::IdxW'(cfg_i.nb - rse_pkg::NbW'(1));
    end else if (busy_q && ready_i) begin
      if (at_last) busy_q <= 1'b0;
      else         idx_q  <= idx_q - rse_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= rem_i;
      bad_q <= cfg_i.bad;
    end
  end

  assign valid_o  = busy_q;
  assign symbol_o = buf_q[idx_q];
  assign index_o  = idx_q;
  assign last_o   = at_last;
  assign bad_o    = bad_q;

endmodule

`default_nettype wire
